FILE: src/box_to_gimbal_angle_frame_defines.svh
// Assertion macros for the box-to-gimbal angle frame encoder.
// Used by the top level only; expects clk and rst in scope.
`ifndef BOX_TO_GIMBAL_ANGLE_FRAME_DEFINES_SVH
`define BOX_TO_GIMBAL_ANGLE_FRAME_DEFINES_SVH
`ifndef SYNTHESIS
`define BGAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BGAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BGAF_ASSERT(lbl, prop, msg)
`define BGAF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/bgaf_pkg.sv
// Shared types, constants and CORDIC helpers for the angle frame encoder.
// No dependencies.
package bgaf_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CORDIC_STEPS   = 18;
  localparam int PRESHIFT       = 14;
  localparam int QBITS          = 15;          // quotient bits below saturation
  localparam int XW             = 36;          // CORDIC x/y width
  localparam int ZW             = 26;          // angle accumulator width
  localparam int DXW            = 19;          // half-pixel offset width
  localparam int NW             = 39;          // dividend width
  localparam int DW             = 26;          // divisor width
  localparam int QW             = NW + 2;      // compare width
  localparam int FRAME_LEN      = 10;

  localparam logic [15:0] CODE_FULL = 16'd32767;
  localparam logic [22:0] DEG90_Q16 = 23'd5898240;
  // reciprocal of 100 scaled by 2^29, rounded up
  localparam logic [22:0] RECIP_100 = 23'd5368710;
  localparam int          RECIP_SH  = 29;
  localparam logic [7:0]  SYNC_START = 8'h73;
  localparam logic [7:0]  SYNC_END   = 8'h65;

  localparam logic [1:0] REG_CENTER_X  = 2'd0;
  localparam logic [1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [1:0] REG_FOCAL     = 2'd2;
  localparam logic [1:0] REG_DIST_PROD = 2'd3;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
    26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115,
    26'sd57, 26'sd29
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } axis_t;

  typedef struct packed {
    logic          vld;
    axis_t         yaw;
    axis_t         pitch;
    logic          yneg;
    logic          pneg;
    logic          ynz;
    logic          pnz;
    logic          fz;
    logic [NW-1:0] rem;
    logic [DW-1:0] dsor;
    logic [QBITS-1:0] quo;
    logic          sat;
    logic [15:0]   delay;
  } stage_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] dist_code;
    logic [15:0] delay;
  } word_t;

  // arithmetic right shift rounding toward zero
  function automatic logic signed [XW-1:0] shr_trunc(logic signed [XW-1:0] v, int s);
    logic signed [XW-1:0] r;
    if (v[XW-1]) r = -((-v) >>> s);
    else r = v >>> s;
    return r;
  endfunction

  // one vectoring rotation
  function automatic axis_t rot(axis_t a, int i);
    axis_t r;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    xs = shr_trunc(a.x, i);
    ys = shr_trunc(a.y, i);
    if (!a.y[XW-1]) begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + ATAN_TAB[i];
    end else begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - ATAN_TAB[i];
    end
    return r;
  endfunction

endpackage

FILE: src/bgaf_cell.sv
// One cell of the chain: a CORDIC step for yaw and pitch and, by STEP, a
// saturation check or one restoring-division step for distance. Depends on bgaf_pkg.
module bgaf_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  bgaf_pkg::stage_t d,
  output bgaf_pkg::stage_t q
);
  import bgaf_pkg::*;

  localparam int SH  = (STEP <= QBITS) ? QBITS - STEP : 0;
  localparam int QIX = (STEP >= 1 && STEP <= QBITS) ? QBITS - STEP : 0;

  stage_t        n;
  logic [QW-1:0] t;
  logic [QW-1:0] r;

  // rotate both axes, then check saturation or try one quotient bit
  always_comb begin
    n       = d;
    n.yaw   = rot(d.yaw, STEP);
    n.pitch = rot(d.pitch, STEP);
    t       = QW'(d.dsor) << SH;
    r       = QW'(d.rem);
    if (STEP == 0) begin
      n.sat = d.sat | (r >= t);
    end else if (STEP <= QBITS) begin
      if (r >= t) begin
        n.rem      = NW'(r - t);
        n.quo[QIX] = 1'b1;
      end
    end
  end

  // hand on to the next cell
  always_ff @(posedge clk) begin
    if (rst) q <= '0;
    else q <= n;
  end

endmodule

FILE: src/bgaf_scale.sv
// Converts the chain result into yaw, pitch and distance codes over three
// registered steps. Depends on bgaf_pkg.
module bgaf_scale (
  input  logic             clk,
  input  logic             rst,
  input  bgaf_pkg::stage_t s,
  output bgaf_pkg::word_t  w
);
  import bgaf_pkg::*;

  logic [22:0] zc [2];
  logic [37:0] p  [2];
  logic [21:0] a  [2];
  logic [44:0] m  [2];
  logic [15:0] c  [2];
  logic        neg_a [2];
  logic        neg_b [2];
  logic        vld_a, vld_b;
  logic [15:0] dist_a, dist_b, delay_a, delay_b;
  logic signed [ZW-1:0] zin [2];
  logic        nz [2];

  assign zin[0] = s.yaw.z;
  assign zin[1] = s.pitch.z;
  assign nz[0]  = s.ynz;
  assign nz[1]  = s.pnz;

  // clamp the angle and scale by 32767/65536
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (s.fz) zc[k] = nz[k] ? DEG90_Q16 : 23'd0;
      else if (zin[k] < 0) zc[k] = 23'd0;
      else if (zin[k] > $signed({3'b0, DEG90_Q16})) zc[k] = DEG90_Q16;
      else zc[k] = zin[k][22:0];
      p[k] = {zc[k], 15'b0} - 38'(zc[k]);
    end
  end

  always_ff @(posedge clk) begin
    a[0]     <= p[0][37:16];
    a[1]     <= p[1][37:16];
    neg_a[0] <= s.yneg;
    neg_a[1] <= s.pneg;
    dist_a   <= s.sat ? CODE_FULL : {1'b0, s.quo};
    delay_a  <= s.delay;
    if (rst) vld_a <= 1'b0;
    else vld_a <= s.vld;
  end

  // divide by 100 through the reciprocal
  always_ff @(posedge clk) begin
    m[0]    <= 45'(a[0]) * 45'(RECIP_100);
    m[1]    <= 45'(a[1]) * 45'(RECIP_100);
    neg_b   <= neg_a;
    dist_b  <= dist_a;
    delay_b <= delay_a;
    if (rst) vld_b <= 1'b0;
    else vld_b <= vld_a;
  end

  // apply the sign and hold the frame words
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      c[k] = m[k][RECIP_SH +: 16];
      if (neg_b[k]) c[k] = -c[k];
    end
  end

  always_ff @(posedge clk) begin
    w.yaw       <= c[0];
    w.pitch     <= c[1];
    w.dist_code <= dist_b;
    w.delay     <= delay_b;
    if (rst) w.vld <= 1'b0;
    else w.vld <= vld_b;
  end

endmodule

FILE: src/box_to_gimbal_angle_frame.sv
// Top level of the box-to-gimbal angle frame encoder: request capture,
// cell chain, scaling and frame output. Depends on bgaf_pkg, bgaf_cell, bgaf_scale.
//
// Usage:
//   Configuration: write cfg_data to register cfg_index with cfg_we; only
//   while no request is in flight. Indexes: centre x, centre y, focal
//   length, distance product.
//   Request: box_x, box_y, box_width, box_height and shot_delay are taken
//   at a clock edge with start high and busy low.
//   Result: a ten-byte frame, one byte a cycle on frame_byte with strobe
//   high; last_byte marks the closing byte. The receiver cannot stall.
//   An all-zero box yields no frame and leaves busy low.
// Flow: the request is registered into the head of the chain, passes the
//   cells and the scale registers, and its frame then shifts out.
// Busy: set by a non-empty request and held while a hold counter loaded
//   from the frame length less one runs down; new requests wait. Up to two
//   requests are in the 18-cell chain at once.
// Reset: rst clears every valid flag, the output counter and busy, and
//   restores the configuration registers to their reset values.
module box_to_gimbal_angle_frame #(
  parameter int COORD_BITS = bgaf_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS-1:0] box_width,
  input  logic [COORD_BITS-1:0] box_height,
  input  logic [15:0]           shot_delay,
  output logic                  strobe,
  output logic [7:0]            frame_byte,
  output logic                  last_byte
);
  import bgaf_pkg::*;

  localparam int SW = COORD_BITS + 2;

  logic [11:0] center_x, center_y;
  logic [15:0] focal_length;
  logic [23:0] distance_product;

  logic [3:0]  hold;
  logic        accept, empty;
  logic [SW-1:0] sum_x, sum_y;
  logic signed [DXW-1:0] dx, dy, mag_x, mag_y;
  logic [NW-1:0] n_val;
  logic [DW-1:0] d_val;

  stage_t s [CORDIC_STEPS+1];
  word_t  w;
  logic [8*FRAME_LEN-1:0] shreg;
  logic [3:0] cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x         <= 12'd320;
      center_y         <= 12'd240;
      focal_length     <= 16'd1000;
      distance_product <= 24'd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  center_x         <= cfg_data[11:0];
        REG_CENTER_Y:  center_y         <= cfg_data[11:0];
        REG_FOCAL:     focal_length     <= cfg_data[15:0];
        REG_DIST_PROD: distance_product <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign accept = start && !busy;
  assign empty  = (box_x == '0) && (box_y == '0) && (box_width == '0) && (box_height == '0);
  assign busy   = (hold != 4'd0);

  // block new requests while the hold counter runs down after a non-empty request
  always_ff @(posedge clk) begin
    if (rst) hold <= 4'd0;
    else if (accept && !empty) hold <= 4'(FRAME_LEN - 1);
    else if (hold != 4'd0) hold <= hold - 4'd1;
  end

  // centre offset in half pixels, dividend and divisor
  always_comb begin
    sum_x = SW'({box_x, 1'b0}) + SW'(box_width);
    sum_y = SW'({box_y, 1'b0}) + SW'(box_height);
    dx    = $signed(DXW'(sum_x)) - $signed(DXW'({center_x, 1'b0}));
    dy    = $signed(DXW'(sum_y)) - $signed(DXW'({center_y, 1'b0}));
    mag_x = dx[DXW-1] ? -dx : dx;
    mag_y = dy[DXW-1] ? -dy : dy;
    n_val = (NW'(distance_product) << 15) - NW'(distance_product);
    d_val = (DW'(box_height) << 10) - (DW'(box_height) << 4) - (DW'(box_height) << 3);
  end

  // capture the request into the head of the chain
  always_ff @(posedge clk) begin
    s[0].yaw.x   <= XW'({focal_length, 1'b0}) << PRESHIFT;
    s[0].yaw.y   <= XW'(mag_x) << PRESHIFT;
    s[0].yaw.z   <= '0;
    s[0].pitch.x <= XW'({focal_length, 1'b0}) << PRESHIFT;
    s[0].pitch.y <= XW'(mag_y) << PRESHIFT;
    s[0].pitch.z <= '0;
    s[0].yneg    <= dx[DXW-1];
    s[0].pneg    <= !dy[DXW-1] && (dy != '0);
    s[0].ynz     <= (dx != '0);
    s[0].pnz     <= (dy != '0);
    s[0].fz      <= (focal_length == 16'd0);
    s[0].rem     <= n_val;
    s[0].dsor    <= d_val;
    s[0].quo     <= '0;
    s[0].sat     <= (box_height == '0);
    s[0].delay   <= shot_delay;
    if (rst) s[0].vld <= 1'b0;
    else s[0].vld <= accept && !empty;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    bgaf_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .rst (rst),
      .d   (s[g]),
      .q   (s[g+1])
    );
  end

  bgaf_scale u_scale (
    .clk (clk),
    .rst (rst),
    .s   (s[CORDIC_STEPS]),
    .w   (w)
  );

  // shift the frame out a byte a cycle
  always_ff @(posedge clk) begin
    if (w.vld) shreg <= {SYNC_START, w.yaw, w.pitch, w.dist_code, w.delay, SYNC_END};
    else shreg <= shreg << 8;
    if (rst) cnt <= 4'd0;
    else if (w.vld) cnt <= 4'(FRAME_LEN);
    else if (cnt != 4'd0) cnt <= cnt - 4'd1;
  end

  assign strobe     = (cnt != 4'd0);
  assign frame_byte = shreg[8*FRAME_LEN-1 -: 8];
  assign last_byte  = (cnt == 4'd1);

`include "box_to_gimbal_angle_frame_defines.svh"
  `BGAF_ASSERT(a_busy_after_req, accept && !empty |=> busy, "busy not raised after request")
  `BGAF_ASSERT(a_last_is_end, last_byte |-> frame_byte == SYNC_END, "bad closing byte")
  `BGAF_ASSERT(a_first_is_start, $rose(strobe) |-> frame_byte == SYNC_START, "bad opening byte")
  `BGAF_ASSERT_ALWAYS(a_last_has_strobe, last_byte |-> strobe, "last byte without strobe")

endmodule

FILE: tb/box_to_gimbal_angle_frame_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the box-to-gimbal angle frame encoder.
// Depends on bgaf_pkg and box_to_gimbal_angle_frame; predicts each frame in SystemVerilog.
module box_to_gimbal_angle_frame_tb;
  import bgaf_pkg::*;

  typedef struct {
    logic [11:0] bx;
    logic [11:0] by;
    logic [11:0] bw;
    logic [11:0] bh;
    logic [15:0] delay;
  } box_req_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_CENTER_X;
  logic [23:0] cfg_data = '0;
  logic start = 0;
  logic busy;
  logic [11:0] box_x = '0, box_y = '0, box_width = '0, box_height = '0;
  logic [15:0] shot_delay = '0;
  logic strobe;
  logic [7:0] frame_byte;
  logic last_byte;

  box_req_t   pending_reqs[$];
  frame_out_t expected_bytes[$];
  int errors = 0;
  int frames_seen = 0;
  int reqs_sent = 0;
  int send_idle_pct = 0;

  // predictor copy of the registers
  longint cx = 320, cy = 240, focal = 1000, dprod = 1000000;

  box_to_gimbal_angle_frame dut (.*);

  always #5 clk = ~clk;

  function automatic longint trunc_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // atan of num/den in degrees Q16 by vectoring CORDIC
  function automatic longint atan_deg(longint num, longint den);
    longint x, y, z, xs, ys;
    z = 0;
    if (den == 0) return (num > 0) ? 64'd5898240 : 0;
    x = den <<< PRESHIFT;
    y = num <<< PRESHIFT;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = trunc_shift(x, i);
      ys = trunc_shift(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 5898240) z = 5898240;
    return z;
  endfunction

  function automatic longint angle_to_code(longint off2);
    longint mag, c;
    mag = (off2 < 0) ? -off2 : off2;
    c = (atan_deg(mag, 2 * focal) * 32767) / (100 * 65536);
    return (off2 < 0) ? -c : c;
  endfunction

  // queue the ten frame bytes that a box request should produce
  task automatic predict_frame(box_req_t r);
    longint dx2, dy2, yaw, pitch, dist_code;
    logic [7:0] fb[10];
    if (r.bx == 0 && r.by == 0 && r.bw == 0 && r.bh == 0) return;
    dx2 = 2 * longint'(r.bx) + r.bw - 2 * cx;
    dy2 = 2 * longint'(r.by) + r.bh - 2 * cy;
    yaw = angle_to_code(dx2);
    pitch = -angle_to_code(dy2);
    if (r.bh == 0) dist_code = 32767;
    else begin
      dist_code = (dprod * 32767) / (1000 * longint'(r.bh));
      if (dist_code > 32767) dist_code = 32767;
    end
    fb[0] = SYNC_START;
    fb[1] = yaw[15:8];   fb[2] = yaw[7:0];
    fb[3] = pitch[15:8]; fb[4] = pitch[7:0];
    fb[5] = dist_code[15:8];  fb[6] = dist_code[7:0];
    fb[7] = r.delay[15:8]; fb[8] = r.delay[7:0];
    fb[9] = SYNC_END;
    for (int k = 0; k < 10; k++) expected_bytes.push_back('{fb[k], k == 9});
  endtask

  // driver: present the next request and drop it once accepted
  logic accepted;
  always @(posedge clk) begin
    accepted <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      predict_frame(pending_reqs[0]);
      void'(pending_reqs.pop_front());
      reqs_sent++;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (start && !accepted) begin
        // hold the request
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1;
        box_x <= pending_reqs[0].bx;
        box_y <= pending_reqs[0].by;
        box_width <= pending_reqs[0].bw;
        box_height <= pending_reqs[0].bh;
        shot_delay <= pending_reqs[0].delay;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: compare each strobed byte with the oldest expectation
  always @(posedge clk) begin
    frame_out_t e;
    if (!rst && strobe) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, frame_byte, last_byte);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        if (frame_byte !== e.data || last_byte !== e.last) begin
          $display("%0t: byte exp %h/%b got %h/%b", $time, e.data, e.last,
                   frame_byte, last_byte);
          errors++;
        end
        if (e.last) frames_seen++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_CENTER_X:  cx = val[11:0];
      REG_CENTER_Y:  cy = val[11:0];
      REG_FOCAL:     focal = val[15:0];
      REG_DIST_PROD: dprod = val[23:0];
      default: ;
    endcase
  endtask

  function automatic box_req_t random_box();
    box_req_t r;
    int sel;
    sel = $urandom_range(9);
    r.delay = 16'($urandom);
    if (sel < 6) begin
      // plausible box around the image
      r.bx = 12'($urandom_range(800)); r.by = 12'($urandom_range(600));
      r.bw = 12'($urandom_range(200)); r.bh = 12'($urandom_range(200));
    end else begin
      r.bx = 12'($urandom); r.by = 12'($urandom);
      r.bw = 12'($urandom); r.bh = 12'($urandom);
      if (sel == 9) r.bh = 0;
    end
    return r;
  endfunction

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_box());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: extremes, empty box, zero height, centred box
    pending_reqs.push_back('{0, 0, 0, 0, 16'hFFFF});
    pending_reqs.push_back('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF});
    pending_reqs.push_back('{0, 0, 0, 1, 0});
    pending_reqs.push_back('{320, 240, 0, 0, 16'h5AA5});
    pending_reqs.push_back('{300, 220, 40, 40, 16'hA55A});
    pending_reqs.push_back('{1, 0, 0, 0, 16'h0001});
    pending_reqs.push_back('{0, 12'hFFF, 0, 12'hFFF, 16'h8000});
    pending_reqs.push_back('{12'hFFF, 0, 12'hFFF, 0, 16'h7FFF});
    pending_reqs.push_back('{0, 0, 0, 0, 16'h1234});
    send_idle_pct = 24;
    push_random(50);
    wait_drained();

    // zero focal length, large distance product, corner centre
    write_reg(REG_FOCAL, 0);
    write_reg(REG_DIST_PROD, 24'hFFFFFF);
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 24'h000FFF);
    pending_reqs.push_back('{0, 12'hFFF, 0, 0, 16'h0F0F});
    pending_reqs.push_back('{10, 10, 5, 1, 16'hF0F0});
    send_idle_pct = 61;
    push_random(50);
    wait_drained();

    // maximum focal length, zero product, far centre
    write_reg(REG_FOCAL, 24'h00FFFF);
    write_reg(REG_DIST_PROD, 0);
    write_reg(REG_CENTER_X, 24'h000FFF);
    write_reg(REG_CENTER_Y, 0);
    push_random(50);
    wait_drained();

    // small focal length, no idling
    write_reg(REG_FOCAL, 1);
    write_reg(REG_DIST_PROD, 24'h0F4240);
    write_reg(REG_CENTER_X, 320);
    write_reg(REG_CENTER_Y, 240);
    send_idle_pct = 0;
    push_random(50);
    wait_drained();

    $display("Run covered %0d requests and %0d frames over four register settings.",
             reqs_sent, frames_seen);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
